@@ rtl/decimated_sliding_window_average_assert.svh @@
// assertion macros for the sliding window average block
`ifndef DECIMATED_SLIDING_WINDOW_AVERAGE_ASSERT_SVH
`define DECIMATED_SLIDING_WINDOW_AVERAGE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DSWA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dswa check failed in the same cycle");

// next-cycle implication, checked outside reset
`define DSWA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dswa check failed one cycle later");

`endif

@@ rtl/dswa_pkg.sv @@
// shared types and constants of the sliding window average block
package dswa_pkg;

	localparam int MAX_WINDOW = 128;
	localparam int COV_BITS   = 16;
	localparam int AVG_BITS   = 16;
	localparam int POS_BITS   = 32;
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int SUM_W      = COV_BITS + $clog2(MAX_WINDOW);
	localparam int STEP_MAX   = 4096;
	localparam int STEP_CFG_W = 13;
	localparam int STEP_W     = $clog2(STEP_MAX);
	localparam int QDEPTH     = 4;
	localparam int Q_AW       = $clog2(QDEPTH);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = STEP_CFG_W;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN   = 2'd1;

	localparam logic [WIN_W-1:0]      WINDOW_LEN_RESET = 8'd100;
	localparam logic [STEP_CFG_W-1:0] STEP_LEN_RESET   = 13'd50;

	typedef struct packed {
		logic [COV_BITS-1:0] coverage;
		logic                last_of_sequence;
	} in_t;

	typedef struct packed {
		logic [POS_BITS-1:0] window_center;
		logic [AVG_BITS-1:0] window_average;
		logic                short_sequence;
	} out_t;

	// one pending division: sum over divisor, with its reported position
	typedef struct packed {
		logic [POS_BITS-1:0] center;
		logic [SUM_W-1:0]    sum;
		logic [WIN_W-1:0]    divisor;
		logic                short_seq;
	} job_t;

endpackage

@@ rtl/dswa_ram.sv @@
// generic single-write, single-read ram with registered read data
module dswa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/dswa_front.sv @@
// front end: window bookkeeping, delay line access and result scheduling
module dswa_front import dswa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  ram_we,
	output logic [ADDR_W-1:0]     ram_addr,
	output logic [COV_BITS-1:0]   ram_wdata,
	input  logic [COV_BITS-1:0]   ram_rdata,
	output logic                  push,
	output job_t                  push_data,
	input  logic                  q_full
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                state_q;
	logic [WIN_W-1:0]      window_len_q;
	logic [STEP_CFG_W-1:0] step_len_q;
	logic [COV_BITS-1:0]   cov_q;
	logic                  last_q;
	logic [WIN_W-1:0]      win_q;
	logic [SUM_W-1:0]      sum_q;
	logic [POS_BITS-1:0]   count_q;
	logic [STEP_W-1:0]     step_q;
	logic [ADDR_W-1:0]     pos_q;

	logic [WIN_W-1:0]      eff_win;
	logic [STEP_CFG_W-1:0] eff_step;
	logic [POS_BITS-1:0]   win_ext;
	logic [POS_BITS-1:0]   idx_p1;
	logic                  fill;
	logic [SUM_W-1:0]      sum_nxt;
	logic                  step_hit;
	logic                  full_emit;
	logic                  short_emit;
	logic [WIN_W-1:0]      pos_p1;

	always_comb begin
		eff_win = window_len_q;
		if (window_len_q == '0) begin
			eff_win = WIN_W'(1);
		end else if (window_len_q > WIN_W'(MAX_WINDOW)) begin
			eff_win = WIN_W'(MAX_WINDOW);
		end
		eff_step = step_len_q;
		if (step_len_q == '0) begin
			eff_step = STEP_CFG_W'(1);
		end else if (step_len_q > STEP_CFG_W'(STEP_MAX)) begin
			eff_step = STEP_CFG_W'(STEP_MAX);
		end
	end

	assign in_ready = (state_q == S_IDLE) && !q_full;

	assign win_ext    = POS_BITS'(win_q);
	assign idx_p1     = count_q + POS_BITS'(1);
	assign fill       = count_q < win_ext;
	assign sum_nxt    = fill ? sum_q + SUM_W'(cov_q)
	                         : sum_q + SUM_W'(cov_q) - SUM_W'(ram_rdata);
	assign step_hit   = ({1'b0, step_q} + STEP_CFG_W'(1)) >= eff_step;
	assign full_emit  = fill ? (idx_p1 == win_ext) : step_hit;
	assign short_emit = last_q && (idx_p1 < win_ext);
	assign pos_p1     = WIN_W'(pos_q) + WIN_W'(1);

	// read at the ring position while idle, write it back in the exec cycle
	assign ram_addr  = pos_q;
	assign ram_we    = (state_q == S_EXEC);
	assign ram_wdata = cov_q;

	assign push = (state_q == S_EXEC) && (full_emit || short_emit);

	always_comb begin
		if (short_emit) begin
			push_data.center    = idx_p1 >> 1;
			push_data.divisor   = idx_p1[WIN_W-1:0];
			push_data.short_seq = 1'b1;
		end else begin
			push_data.center    = fill ? POS_BITS'(win_q >> 1)
			                           : count_q - POS_BITS'(win_q >> 1) + POS_BITS'(1);
			push_data.divisor   = win_q;
			push_data.short_seq = 1'b0;
		end
		push_data.sum = sum_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RESET;
			step_len_q   <= STEP_LEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WINDOW_LEN: window_len_q <= cfg_data[WIN_W-1:0];
				CFG_STEP_LEN:   step_len_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			win_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
			step_q  <= '0;
			pos_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cov_q  <= in_data.coverage;
						last_q <= in_data.last_of_sequence;
						// window length is held for the whole sequence
						if (count_q == '0) begin
							win_q <= eff_win;
						end
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (last_q) begin
						sum_q   <= '0;
						count_q <= '0;
						step_q  <= '0;
						pos_q   <= '0;
					end else begin
						sum_q <= sum_nxt;
						if (count_q != '1) begin
							count_q <= idx_p1;
						end
						if (!fill) begin
							step_q <= step_hit ? '0 : step_q + STEP_W'(1);
						end
						pos_q <= (pos_p1 >= win_q) ? '0 : pos_p1[ADDR_W-1:0];
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/dswa_fifo.sv @@
// short queue of pending divisions between front and back
module dswa_fifo import dswa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t pop_data,
	output logic empty
);

	job_t            entry_q [QDEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign full     = cnt_q == (Q_AW+1)'(QDEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (Q_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_AW+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/dswa_back.sv @@
// back end: bit-serial divider and output register
module dswa_back import dswa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  job_t q_data,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int REM_W = WIN_W + 1;
	localparam int CNT_W = $clog2(SUM_W + 1);

	typedef enum logic [1:0] {B_IDLE, B_DIV, B_DONE} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    quo_q;
	logic [REM_W-1:0]    rem_q;
	logic [WIN_W-1:0]    div_q;
	logic [POS_BITS-1:0] center_q;
	logic                short_q;

	logic [REM_W-1:0]    rem_sh;
	logic                take;

	assign pop    = (state_q == B_IDLE) && !q_empty;
	assign rem_sh = {rem_q[REM_W-2:0], quo_q[SUM_W-1]};
	assign take   = rem_sh >= REM_W'(div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// a result leaving while the next one is handed over keeps valid high
			if (out_valid && out_ready && (state_q != B_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						quo_q    <= q_data.sum;
						rem_q    <= '0;
						div_q    <= q_data.divisor;
						center_q <= q_data.center;
						short_q  <= q_data.short_seq;
						cnt_q    <= CNT_W'(SUM_W);
						state_q  <= B_DIV;
					end
				end
				B_DIV: begin
					// one quotient bit per cycle, shifted in from the right
					rem_q <= take ? rem_sh - REM_W'(div_q) : rem_sh;
					quo_q <= {quo_q[SUM_W-2:0], take};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid               <= 1'b1;
						out_data.window_center  <= center_q;
						out_data.window_average <= quo_q[AVG_BITS-1:0];
						out_data.short_sequence <= short_q;
						state_q                 <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/decimated_sliding_window_average.sv @@
// top level of the decimated sliding window average block
//
// coverage samples enter on in_valid/in_ready, one sequence at a time, with
// last_of_sequence on the final sample; window averages leave on
// out_valid/out_ready, at most one per sample.
// window_len and step_len are written through cfg_valid/cfg_index/cfg_data
// while the block is idle, a rule on the user that the block does not enforce;
// cfg_ready is always high, unknown indexes are dropped. window_len is taken
// at the first sample of each sequence. the delay line memory is read at
// the ring position in one cycle and written back in the next.
// each average is loaded into a bit-serial divider, which forms all 23
// quotient bits of the sum and then hands the result to the output register.
// a 4-entry queue holds pending divisions; when it is full the input side
// stalls; until then new samples are taken while earlier averages are still
// being divided.
// a stalled output holds its result in the output register while the
// divider finishes the next one.
// reset clears the counters, running sum and queue and restores the
// register defaults of 100 and 50; the delay line needs no clearing.
module decimated_sliding_window_average import dswa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	`include "decimated_sliding_window_average_assert.svh"

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [COV_BITS-1:0] ram_wdata;
	logic [COV_BITS-1:0] ram_rdata;
	logic                push;
	job_t                push_data;
	logic                q_full;
	logic                pop;
	job_t                pop_data;
	logic                q_empty;

	assign cfg_ready = 1'b1;

	dswa_ram #(
		.WIDTH(COV_BITS),
		.DEPTH(MAX_WINDOW)
	) u_delay_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	dswa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.ram_we   (ram_we),
		.ram_addr (ram_addr),
		.ram_wdata(ram_wdata),
		.ram_rdata(ram_rdata),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	dswa_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty)
	);

	dswa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (pop_data),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// queue never overflows or underflows
	`DSWA_ASSERT_NOW(a_no_push_full, push, !q_full)
	`DSWA_ASSERT_NOW(a_no_pop_empty, pop, !q_empty)
	// a transfer in occupies the front for its write-back cycle
	`DSWA_ASSERT_NEXT(a_front_busy, in_valid && in_ready, !in_ready && ram_we)

endmodule

@@ tb/tb_decimated_sliding_window_average.sv @@
// self-checking testbench for the decimated sliding window average block
module tb_decimated_sliding_window_average;
	import dswa_pkg::*;

	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES  = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_t                  out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	decimated_sliding_window_average u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// control shared between the test sequence and the receiver, and the error count
	bit idle_on;
	bit hold_req;
	int err_count;

	// predictor state
	logic [COV_BITS-1:0]   hist_mem [MAX_WINDOW];
	logic [31:0]           acc_sum;
	logic [31:0]           seen_count;
	logic [31:0]           steps_since;
	int unsigned           ring_wr;
	int unsigned           win_now;
	logic [7:0]            reg_window;
	logic [STEP_CFG_W-1:0] reg_step;
	out_t                  avg_expected_q [$];

	function automatic int unsigned clamp_window(input logic [7:0] v);
		if (v < 1) return 1;
		if (v > MAX_WINDOW) return MAX_WINDOW;
		return v;
	endfunction

	function automatic int unsigned clamp_step(input logic [STEP_CFG_W-1:0] v);
		if (v < 1) return 1;
		if (v > STEP_MAX) return STEP_MAX;
		return v;
	endfunction

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_WINDOW_LEN: reg_window = data[7:0];
			CFG_STEP_LEN: reg_step = data;
			default: ;
		endcase
	endfunction

	function automatic void predict_sample(input in_t s);
		logic [31:0] idx;
		int unsigned w;
		int unsigned len;
		out_t r;
		bit hit;
		idx = seen_count;
		hit = 0;
		r = '0;
		if (idx == 0) win_now = clamp_window(reg_window);
		w = win_now;
		if (w < 1 || w > MAX_WINDOW) w = 1;
		if (ring_wr >= w) ring_wr = 0;
		if (idx < w) begin
			acc_sum = acc_sum + s.coverage;
			hist_mem[ring_wr] = s.coverage;
			if (idx + 1 == w) begin
				r.window_center  = w / 2;
				r.window_average = 16'(acc_sum / w);
				r.short_sequence = 1'b0;
				hit = 1;
			end
		end else begin
			acc_sum = acc_sum + s.coverage - hist_mem[ring_wr];
			hist_mem[ring_wr] = s.coverage;
			if (steps_since + 1 >= clamp_step(reg_step)) begin
				steps_since = 0;
				r.window_center  = idx - 32'(w / 2) + 32'd1;
				r.window_average = 16'(acc_sum / w);
				r.short_sequence = 1'b0;
				hit = 1;
			end else begin
				steps_since = steps_since + 1;
			end
		end
		ring_wr = (ring_wr + 1 >= w) ? 0 : ring_wr + 1;
		if (seen_count != 32'hFFFF_FFFF) seen_count = seen_count + 1;
		if (s.last_of_sequence) begin
			// sequence shorter than the window: one mean over what came in
			if (idx + 1 < w) begin
				len = idx + 1;
				r.window_center  = len / 2;
				r.window_average = 16'(acc_sum / len);
				r.short_sequence = 1'b1;
				hit = 1;
			end
			acc_sum     = 0;
			seen_count  = 0;
			steps_since = 0;
			ring_wr     = 0;
		end
		if (hit) avg_expected_q.push_back(r);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_result(input out_t got);
		out_t want;
		if (avg_expected_q.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected: %p", got));
			return;
		end
		want = avg_expected_q.pop_front();
		if (got.window_center !== want.window_center)
			report_mismatch($sformatf("window_center got %0d want %0d",
				got.window_center, want.window_center));
		if (got.window_average !== want.window_average)
			report_mismatch($sformatf("window_average got %0d want %0d",
				got.window_average, want.window_average));
		if (got.short_sequence !== want.short_sequence)
			report_mismatch($sformatf("short_sequence got %0b want %0b",
				got.short_sequence, want.short_sequence));
	endtask

	// output check first, then the new sample, then register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) check_result(out_data);
			if (in_valid && in_ready) predict_sample(in_data);
			if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
		end
	end

	// receiver: random stall bursts, plus a long hold on request
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 9);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one sample transfer; valid stays high across back-to-back items
	task automatic send_cov(input logic [COV_BITS-1:0] c, input bit l);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= in_t'{coverage: c, last_of_sequence: l};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [COV_BITS-1:0] pick_cov();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return COV_BITS'($urandom);
		endcase
	endfunction

	task automatic send_run(input int len, input bit close);
		for (int j = 0; j < len; j++) send_cov(pick_cov(), close && (j == len - 1));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (avg_expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_default_short();
		send_cov(16'h0003, 1'b0);
		send_cov(16'hFFFF, 1'b1);
		wait_drained();
	endtask

	task automatic test_unit_window();
		write_reg(CFG_WINDOW_LEN, 13'd1);
		write_reg(CFG_STEP_LEN, 13'd1);
		send_cov(16'h0000, 1'b0);
		send_cov(16'hFFFF, 1'b0);
		send_cov(16'h1234, 1'b1);
		wait_drained();
		// zero window length acts as one
		write_reg(CFG_WINDOW_LEN, 13'd0);
		send_cov(16'hABCD, 1'b1);
		wait_drained();
	endtask

	task automatic test_window_edges();
		write_reg(CFG_WINDOW_LEN, 13'd4);
		write_reg(CFG_STEP_LEN, 13'd2);
		// sequence exactly one window long
		repeat (3) send_cov(16'hFFFF, 1'b0);
		send_cov(16'hFFFF, 1'b1);
		for (int j = 0; j < 6; j++) send_cov((j % 2) ? 16'hFFFF : 16'h0000, j == 5);
		send_cov(16'h8001, 1'b1);
		wait_drained();
	endtask

	task automatic test_reg_clamp();
		write_reg(CFG_WINDOW_LEN, 13'd200);
		send_cov(16'h7FFF, 1'b0);
		send_cov(16'h8000, 1'b1);
		wait_drained();
		write_reg(CFG_WINDOW_LEN, 13'd2);
		write_reg(CFG_STEP_LEN, 13'd0);
		send_run(4, 1'b1);
		wait_drained();
		write_reg(CFG_STEP_LEN, 13'h1FFF);
		// unknown indexes must leave both registers alone
		write_reg(2'd2, 13'h1555);
		write_reg(2'd3, 13'h0AAA);
		send_run(3, 1'b1);
		wait_drained();
	endtask

	task automatic test_change_mid_sequence();
		write_reg(CFG_WINDOW_LEN, 13'd3);
		write_reg(CFG_STEP_LEN, 13'd1);
		send_run(4, 1'b0);
		wait_drained();
		// window stays latched, step length takes effect at once
		write_reg(CFG_WINDOW_LEN, 13'd8);
		write_reg(CFG_STEP_LEN, 13'd2);
		send_run(5, 1'b1);
		send_run(3, 1'b1);
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_reg(CFG_WINDOW_LEN, 13'd1);
		write_reg(CFG_STEP_LEN, 13'd1);
		hold_req = 1;
		send_run(40, 1'b1);
		// sender pauses until everything has come out
		wait_drained();
	endtask

	task automatic run_random_phase(input logic [CFG_DATA_W-1:0] wd,
			input logic [CFG_DATA_W-1:0] sd, input int n_items);
		int unsigned w;
		int unsigned s;
		int sent;
		int len;
		write_reg(CFG_WINDOW_LEN, wd);
		write_reg(CFG_STEP_LEN, sd);
		w = clamp_window(wd[7:0]);
		s = clamp_step(sd);
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0: len = (w > 1) ? $urandom_range(1, w - 1) : 1;
				1: len = w;
				2: len = $urandom_range(1, 3);
				default: len = w + $urandom_range(0, (s * 3 > 200) ? 200 : s * 3);
			endcase
			send_run(len, 1'b1);
			sent += len;
			if ($urandom_range(0, 19) == 0) wait_drained();
		end
		wait_drained();
	endtask

	task automatic test_random();
		run_random_phase(13'd1, 13'd1, 200);
		run_random_phase(13'd128, 13'd1, 300);
		run_random_phase(13'd128, 13'd4096, 250);
		run_random_phase(13'd100, 13'd50, 250);
		run_random_phase(13'd7, 13'($urandom_range(1, 20)), 250);
		run_random_phase(13'($urandom), 13'($urandom_range(0, 64)), 250);
		run_random_phase(13'($urandom_range(2, 16)), 13'($urandom), 200);
		idle_on = 0;
		run_random_phase(13'($urandom_range(1, 12)), 13'($urandom_range(1, 6)), 250);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1;
		hold_req = 0;
		err_count = 0;
		acc_sum = 0;
		seen_count = 0;
		steps_since = 0;
		ring_wr = 0;
		win_now = 0;
		reg_window = WINDOW_LEN_RESET;
		reg_step = STEP_LEN_RESET;
		for (int k = 0; k < MAX_WINDOW; k++) hist_mem[k] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_short();
		test_unit_window();
		test_window_edges();
		test_reg_clamp();
		test_change_mid_sequence();
		test_backpressure();
		test_random();

		wait_drained();
		if (avg_expected_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", avg_expected_q.size()));
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ decimated_sliding_window_average.f @@
+incdir+rtl
rtl/dswa_pkg.sv
rtl/dswa_ram.sv
rtl/dswa_front.sv
rtl/dswa_fifo.sv
rtl/dswa_back.sv
rtl/decimated_sliding_window_average.sv
tb/tb_decimated_sliding_window_average.sv
